// ===== hw/rtl/arpc_pkg.sv =====
// Shared constants, types and code points for the ARP responder with cache.
package arpc_pkg;

	localparam int CACHE_ENTRIES = 16;
	localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int LEN_W  = 11;
	localparam int POP_W  = 16;
	localparam int OP_W   = 2;
	localparam int SOP_W  = 2;
	localparam int CFG_W  = 48;

	localparam int MAC_BYTES  = 6;
	localparam int IP_BYTES   = 4;
	localparam int ARP_HDR_B  = 8;
	localparam logic [7:0] BCAST_BYTE = 8'hFF;

	localparam logic [MAC_W-1:0] BCAST_MAC   = {MAC_BYTES{BCAST_BYTE}};
	localparam logic [LEN_W-1:0] ARP_PKT_LEN =
		LEN_W'(ARP_HDR_B + 2 * MAC_BYTES + 2 * IP_BYTES);

	// item opcodes
	localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	// ARP operation field of a received packet
	localparam logic [POP_W-1:0] ARP_REQUEST = 16'd1;
	localparam logic [POP_W-1:0] ARP_REPLY   = 16'd2;

	// operation of a transmitted packet
	localparam logic [SOP_W-1:0] SEND_NONE    = 2'd0;
	localparam logic [SOP_W-1:0] SEND_REQUEST = 2'd1;
	localparam logic [SOP_W-1:0] SEND_REPLY   = 2'd2;

	// configuration register indexes
	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	// outcome of a cache scan and learn, handed from controller to top level
	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] mac;
		logic             full;
	} arpc_stat_t;

endpackage

// ===== hw/rtl/arp_responder_with_cache.sv =====
// ARP responder top level: configuration, item capture, cache RAM and result register.
// A lookup or received packet has its result loaded after a scan of the cache RAM that
//   reads one entry per cycle; a request issue skips the scan. A result is loaded only
//   once the output register is free or being taken; the next transfer in follows the load.
//   One item is in work at a time; the next item can be taken while the previous result
//   still waits in the output register, and its result holds until that one is taken.
// Reset: arst_n clears own_ip, own_mac, all entry valid bits and the output valid flag;
//   no clearing pass is needed, cache RAM contents are only read behind a valid bit.
module arp_responder_with_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [arpc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [arpc_pkg::OP_W-1:0]     opcode,
	input  logic [arpc_pkg::POP_W-1:0]    packet_operation,
	input  logic [arpc_pkg::MAC_W-1:0]    sender_mac,
	input  logic [arpc_pkg::IP_W-1:0]     sender_ip,
	input  logic [arpc_pkg::IP_W-1:0]     target_ip,
	input  logic [arpc_pkg::LEN_W-1:0]    frame_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          send_frame,
	output logic [arpc_pkg::SOP_W-1:0]    send_operation,
	output logic [arpc_pkg::MAC_W-1:0]    send_dest_mac,
	output logic [arpc_pkg::IP_W-1:0]     send_dest_ip,
	output logic [arpc_pkg::LEN_W-1:0]    send_length,
	output logic                          lookup_hit,
	output logic [arpc_pkg::MAC_W-1:0]    found_mac,
	output logic                          cache_full
);
	import arpc_pkg::*;

	// configuration registers
	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;

	// captured item
	logic [OP_W-1:0]  op_q;
	logic [POP_W-1:0] pop_q;
	logic [MAC_W-1:0] smac_q;
	logic [IP_W-1:0]  sip_q;
	logic [IP_W-1:0]  tip_q;
	logic [LEN_W-1:0] flen_q;

	logic       idle;
	logic       fin;
	logic       accept;
	logic       out_free;
	logic       aimed;
	logic       learn_req;
	logic       reply_req;
	logic       in_scan;
	logic [IP_W-1:0] key_ip;
	arpc_stat_t stat;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [IP_W+MAC_W-1:0]   ram_wdata;
	logic                    ram_re;
	logic [IDX_W-1:0]        ram_raddr;
	logic [IP_W+MAC_W-1:0]   ram_rdata;

	// next-result values
	logic             nx_frame;
	logic [SOP_W-1:0] nx_sop;
	logic [MAC_W-1:0] nx_dmac;
	logic [IP_W-1:0]  nx_dip;
	logic [LEN_W-1:0] nx_len;
	logic             nx_hit;
	logic [MAC_W-1:0] nx_fmac;
	logic             nx_full;

	// output register: hold a finished result until its transfer out
	logic             out_valid_q;
	logic             send_frame_q;
	logic [SOP_W-1:0] send_operation_q;
	logic [MAC_W-1:0] send_dest_mac_q;
	logic [IP_W-1:0]  send_dest_ip_q;
	logic [LEN_W-1:0] send_length_q;
	logic             lookup_hit_q;
	logic [MAC_W-1:0] found_mac_q;
	logic             cache_full_q;

	assign in_ready = idle;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// receive and lookup both walk the cache; a request issue does not
	assign in_scan = (opcode == OP_RECEIVE) || (opcode == OP_LOOKUP);

	// a received packet only counts when aimed at this station
	assign aimed     = (op_q == OP_RECEIVE) && (tip_q == own_ip_q);
	assign reply_req = aimed && (pop_q == ARP_REQUEST);
	assign learn_req = aimed && (pop_q == ARP_REPLY);
	assign key_ip    = (op_q == OP_LOOKUP) ? tip_q : sip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_IP:  own_ip_q  <= cfg_data[IP_W-1:0];
				REG_OWN_MAC: own_mac_q <= cfg_data[MAC_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the item on its transfer in; held until the result is loaded
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			pop_q  <= packet_operation;
			smac_q <= sender_mac;
			sip_q  <= sender_ip;
			tip_q  <= target_ip;
			flen_q <= frame_length;
		end
	end

	arpc_ram #(
		.WIDTH(IP_W + MAC_W),
		.DEPTH(CACHE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.scan      (in_scan),
		.key_ip    (key_ip),
		.learn_mac (smac_q),
		.learn_req (learn_req),
		.out_free  (out_free),
		.idle      (idle),
		.fin       (fin),
		.stat      (stat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// build the result; anything not named below stays zero
	always_comb begin
		nx_frame = 1'b0;
		nx_sop   = SEND_NONE;
		nx_dmac  = '0;
		nx_dip   = '0;
		nx_len   = '0;
		nx_hit   = 1'b0;
		nx_fmac  = '0;
		nx_full  = 1'b0;
		case (op_q)
			OP_RECEIVE: begin
				if (reply_req) begin
					nx_frame = 1'b1;
					nx_sop   = SEND_REPLY;
					nx_dmac  = smac_q;
					nx_dip   = sip_q;
					nx_len   = flen_q;
				end
				nx_full = stat.full;
			end
			OP_LOOKUP: begin
				nx_hit  = stat.hit;
				nx_fmac = stat.hit ? stat.mac : '0;
			end
			OP_QUERY: begin
				nx_frame = 1'b1;
				nx_sop   = SEND_REQUEST;
				nx_dmac  = BCAST_MAC;
				nx_dip   = tip_q;
				nx_len   = ARP_PKT_LEN;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			send_frame_q     <= nx_frame;
			send_operation_q <= nx_sop;
			send_dest_mac_q  <= nx_dmac;
			send_dest_ip_q   <= nx_dip;
			send_length_q    <= nx_len;
			lookup_hit_q     <= nx_hit;
			found_mac_q      <= nx_fmac;
			cache_full_q     <= nx_full;
		end
	end

	assign out_valid      = out_valid_q;
	assign send_frame     = send_frame_q;
	assign send_operation = send_operation_q;
	assign send_dest_mac  = send_dest_mac_q;
	assign send_dest_ip   = send_dest_ip_q;
	assign send_length    = send_length_q;
	assign lookup_hit     = lookup_hit_q;
	assign found_mac      = found_mac_q;
	assign cache_full     = cache_full_q;

endmodule

// ===== hw/rtl/arpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                                wdata,
	input  logic                                            re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                                rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/arpc_ctrl.sv =====
// Cache controller: entry valid bits, sequential scan of the RAM and write-back.
module arpc_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                scan,
	input  logic [arpc_pkg::IP_W-1:0]           key_ip,
	input  logic [arpc_pkg::MAC_W-1:0]          learn_mac,
	input  logic                                learn_req,
	input  logic                                out_free,
	output logic                                idle,
	output logic                                fin,
	output arpc_pkg::arpc_stat_t                stat,
	output logic                                ram_we,
	output logic [arpc_pkg::IDX_W-1:0]          ram_waddr,
	output logic [arpc_pkg::IP_W+arpc_pkg::MAC_W-1:0] ram_wdata,
	output logic                                ram_re,
	output logic [arpc_pkg::IDX_W-1:0]          ram_raddr,
	input  logic [arpc_pkg::IP_W+arpc_pkg::MAC_W-1:0] ram_rdata
);
	import arpc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

	logic [1:0]               state_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]         iss_q;
	logic                     iss_done_q;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic                     hit_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic [MAC_W-1:0]         hit_mac_q;
	logic                     free_q;
	logic [IDX_W-1:0]         free_idx_q;
	logic [IP_W-1:0]          rd_ip;
	logic [MAC_W-1:0]         rd_mac;
	logic                     rd_entry_valid;

	assign rd_ip          = ram_rdata[IP_W+MAC_W-1:MAC_W];
	assign rd_mac         = ram_rdata[MAC_W-1:0];
	assign rd_entry_valid = valid_q[rd_idx_s1];

	assign idle      = (state_q == ST_IDLE);
	assign fin       = (state_q == ST_FIN) && out_free;
	assign ram_re    = (state_q == ST_SCAN) && !iss_done_q;
	assign ram_raddr = iss_q;

	// write back on a learn: update the matching entry, else take the first free one
	assign ram_we    = fin && learn_req && (hit_q || free_q);
	assign ram_waddr = hit_q ? hit_idx_q : free_idx_q;
	assign ram_wdata = {key_ip, learn_mac};

	assign stat.hit  = hit_q;
	assign stat.mac  = hit_mac_q;
	assign stat.full = learn_req && !hit_q && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			iss_q      <= '0;
			iss_done_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			unique case (state_q)
				ST_IDLE: begin
					iss_q      <= '0;
					iss_done_q <= 1'b0;
					hit_q      <= 1'b0;
					free_q     <= 1'b0;
					if (start) begin
						state_q <= scan ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						if (iss_q == LAST_IDX) begin
							iss_done_q <= 1'b1;
						end else begin
							iss_q <= iss_q + IDX_W'(1);
						end
					end
					if (rd_vld_s1) begin
						if (rd_entry_valid && rd_ip == key_ip && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (!rd_entry_valid && !free_q) begin
							free_q <= 1'b1;
						end
						if (rd_idx_s1 == LAST_IDX) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin) begin
						state_q <= ST_IDLE;
						if (ram_we && !hit_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan payload: index in flight, first match and first free slot
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_idx_s1 <= iss_q;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (rd_entry_valid && rd_ip == key_ip && !hit_q) begin
				hit_idx_q <= rd_idx_s1;
				hit_mac_q <= rd_mac;
			end
			if (!rd_entry_valid && !free_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

endmodule
